// ----- sv/dbe_pkg.sv -----
// Shared types and constants for the debounced button and encoder event block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dbe_pkg;

  localparam int unsigned PIN_COUNT   = 16;
  localparam int unsigned EVENT_COUNT = 20;
  localparam int unsigned BUTTON_COUNT = 6;
  localparam int unsigned ENC_EVENTS  = 7;
  localparam int unsigned TICKS_W     = 8;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd5;

  // Pin positions in the raw word
  localparam int unsigned PIN_PUSH1   = 6;
  localparam int unsigned PIN_PUSH2   = 7;
  localparam int unsigned PIN_ENC1_AO = 8;
  localparam int unsigned PIN_ENC1_BO = 9;
  localparam int unsigned PIN_ENC1_AI = 10;
  localparam int unsigned PIN_ENC1_BI = 11;
  localparam int unsigned PIN_ENC2_AO = 12;
  localparam int unsigned PIN_ENC2_BO = 13;
  localparam int unsigned PIN_ENC2_AI = 14;
  localparam int unsigned PIN_ENC2_BI = 15;

  // Event positions inside one encoder group
  localparam int unsigned EV_PUSH         = 0;
  localparam int unsigned EV_OUTER_CW     = 1;
  localparam int unsigned EV_OUTER_CCW    = 2;
  localparam int unsigned EV_INNER_CW     = 3;
  localparam int unsigned EV_INNER_CCW    = 4;
  localparam int unsigned EV_INNER_CW_ALT = 5;
  localparam int unsigned EV_INNER_CCW_ALT = 6;

  localparam int unsigned ENC1_BASE = 6;
  localparam int unsigned ENC2_BASE = 13;

  // Clean pin levels of one encoder
  typedef struct packed {
    logic push;
    logic a_outer;
    logic b_outer;
    logic a_inner;
    logic b_inner;
  } enc_pins_t;

  typedef struct packed {
    logic [EVENT_COUNT-1:0] new_events;
    logic [EVENT_COUNT-1:0] ascii_pending;
    logic [EVENT_COUNT-1:0] hid_pending;
    logic [PIN_COUNT-1:0]   clean_levels;
  } result_t;

endpackage

// ----- sv/debounce_button_encoder_events_unit.sv -----
// Top level: 16 debounce lanes, two encoder decoders, event merge and output skid.
// Depends on dbe_pkg, dbe_lane and dbe_enc.
//
// Usage: each word on the input channel (in_valid/in_ready) is one debounce
// tick: 16 raw pin levels plus clear strobes for the ASCII and HID flags.
// Every accepted word yields exactly one result word on the output channel
// (out_valid/out_ready): events raised this tick, both sticky flag sets and
// the clean pin levels.
// The result word is registered: it enters the output register, or the skid register when the output is held.
// Throughput: one word per cycle while in_ready is high. All 16 lanes and both
// decoders update together, so the pin state loop closes in one register stage.
// The output side has a result register plus a one-word skid register:
// when the receiver stalls, one more word is still taken, then in_ready
// drops until the skid word drains.
// debounce_ticks is written through cfg_wr_en/cfg_wr_data; the user must write it only while idle (not enforced).
// Reset (rst, synchronous) clears all clean levels, counters, alternate marks
// and flags, empties the output stage and sets debounce_ticks to 5.
`timescale 1ns / 1ps

module debounce_button_encoder_events_unit #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [dbe_pkg::TICKS_W-1:0]        cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dbe_pkg::PIN_COUNT-1:0]      raw_pins,
  input  logic                               clear_ascii,
  input  logic                               clear_hid,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dbe_pkg::EVENT_COUNT-1:0]    new_events,
  output logic [dbe_pkg::EVENT_COUNT-1:0]    ascii_pending,
  output logic [dbe_pkg::EVENT_COUNT-1:0]    hid_pending,
  output logic [dbe_pkg::PIN_COUNT-1:0]      clean_levels
);
  import dbe_pkg::*;

  logic [TICKS_W-1:0]     debounce_ticks;
  logic                   accept;
  logic                   pop;
  logic [PIN_COUNT-1:0]   level;
  logic [PIN_COUNT-1:0]   level_next;
  enc_pins_t              enc1_old;
  enc_pins_t              enc1_new;
  enc_pins_t              enc2_old;
  enc_pins_t              enc2_new;
  logic [ENC_EVENTS-1:0]  enc1_events;
  logic [ENC_EVENTS-1:0]  enc2_events;
  logic [EVENT_COUNT-1:0] events;
  logic [EVENT_COUNT-1:0] ascii_flags;
  logic [EVENT_COUNT-1:0] hid_flags;
  logic [EVENT_COUNT-1:0] ascii_flags_next;
  logic [EVENT_COUNT-1:0] hid_flags_next;
  result_t                result_next;
  result_t                out_word;
  result_t                skid_word;
  logic                   skid_valid;

  assign accept   = in_valid & in_ready;
  assign pop      = out_valid & out_ready;
  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= TICKS_RESET;
    end else if (cfg_wr_en) begin
      debounce_ticks <= cfg_wr_data;
    end
  end

  for (genvar i = 0; i < PIN_COUNT; i++) begin : g_lane
    dbe_lane #(
      .COUNT_BITS (COUNT_BITS)
    ) u_lane (
      .clk        (clk),
      .rst        (rst),
      .en         (accept),
      .raw        (raw_pins[i]),
      .ticks      (debounce_ticks),
      .level      (level[i]),
      .level_next (level_next[i])
    );
  end

  assign enc1_old = '{push: level[PIN_PUSH1], a_outer: level[PIN_ENC1_AO],
                      b_outer: level[PIN_ENC1_BO], a_inner: level[PIN_ENC1_AI],
                      b_inner: level[PIN_ENC1_BI]};
  assign enc1_new = '{push: level_next[PIN_PUSH1], a_outer: level_next[PIN_ENC1_AO],
                      b_outer: level_next[PIN_ENC1_BO], a_inner: level_next[PIN_ENC1_AI],
                      b_inner: level_next[PIN_ENC1_BI]};
  assign enc2_old = '{push: level[PIN_PUSH2], a_outer: level[PIN_ENC2_AO],
                      b_outer: level[PIN_ENC2_BO], a_inner: level[PIN_ENC2_AI],
                      b_inner: level[PIN_ENC2_BI]};
  assign enc2_new = '{push: level_next[PIN_PUSH2], a_outer: level_next[PIN_ENC2_AO],
                      b_outer: level_next[PIN_ENC2_BO], a_inner: level_next[PIN_ENC2_AI],
                      b_inner: level_next[PIN_ENC2_BI]};

  dbe_enc u_enc1 (
    .clk      (clk),
    .rst      (rst),
    .en       (accept),
    .old_pins (enc1_old),
    .new_pins (enc1_new),
    .events   (enc1_events)
  );

  dbe_enc u_enc2 (
    .clk      (clk),
    .rst      (rst),
    .en       (accept),
    .old_pins (enc2_old),
    .new_pins (enc2_new),
    .events   (enc2_events)
  );

  // Merge: button rising edges plus both encoder groups
  assign events = {enc2_events, enc1_events,
                   level_next[BUTTON_COUNT-1:0] & ~level[BUTTON_COUNT-1:0]};

  // Clear acts before this tick's events are set
  assign ascii_flags_next = (clear_ascii ? '0 : ascii_flags) | events;
  assign hid_flags_next   = (clear_hid ? '0 : hid_flags) | events;

  always_ff @(posedge clk) begin
    if (rst) begin
      ascii_flags <= '0;
      hid_flags   <= '0;
    end else if (accept) begin
      ascii_flags <= ascii_flags_next;
      hid_flags   <= hid_flags_next;
    end
  end

  assign result_next = '{new_events: events, ascii_pending: ascii_flags_next,
                         hid_pending: hid_flags_next, clean_levels: level_next};

  // Output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_word <= skid_word;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_word <= result_next;
      end else begin
        out_word <= result_next;
      end
    end
  end

  assign new_events    = out_word.new_events;
  assign ascii_pending = out_word.ascii_pending;
  assign hid_pending   = out_word.hid_pending;
  assign clean_levels  = out_word.clean_levels;

`ifndef NO_ASSERTIONS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with empty output register");

  a_accept_gives_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  a_levels_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(level))
    else $error("clean levels moved without an accepted word");

  a_ascii_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && !clear_ascii) |=> ((ascii_flags & $past(ascii_flags)) == $past(ascii_flags)))
    else $error("ASCII flag dropped without a clear");

  a_hid_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && !clear_hid) |=> ((hid_flags & $past(hid_flags)) == $past(hid_flags)))
    else $error("HID flag dropped without a clear");
`endif

endmodule

// ----- sv/dbe_lane.sv -----
// One debounce lane: saturating mismatch counter and clean level for one pin.
// Depends on dbe_pkg for the tick register width.
`timescale 1ns / 1ps

module dbe_lane #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         raw,
  input  logic [dbe_pkg::TICKS_W-1:0]  ticks,
  output logic                         level,
  output logic                         level_next
);
  import dbe_pkg::*;

  localparam int unsigned CMP_W = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;

  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] count_inc;
  logic [CMP_W-1:0]      count_ext;
  logic [CMP_W-1:0]      ticks_ext;

  assign count_inc = (count == {COUNT_BITS{1'b1}}) ? count : count + 1'b1;
  assign count_ext = CMP_W'(count_inc);
  assign ticks_ext = CMP_W'(ticks);

  // Count stays where it is after a flip; the next matching tick clears it
  always_comb begin
    count_next = '0;
    level_next = level;
    if (raw != level) begin
      count_next = count_inc;
      if (count_ext >= ticks_ext) begin
        level_next = ~level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      level <= 1'b0;
    end else if (en) begin
      count <= count_next;
      level <= level_next;
    end
  end

endmodule

// ----- sv/dbe_enc.sv -----
// Event decoder for one dual-shaft encoder with push pin and alternate mark.
// Depends on dbe_pkg for the pin struct and event positions.
`timescale 1ns / 1ps

module dbe_enc (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  dbe_pkg::enc_pins_t                old_pins,
  input  dbe_pkg::enc_pins_t                new_pins,
  output logic [dbe_pkg::ENC_EVENTS-1:0]    events
);
  import dbe_pkg::*;

  logic alt_used;
  logic alt_used_next;
  logic push_fall;
  logic inner_edge;
  logic outer_edge;
  logic inner_ccw;
  logic outer_ccw;

  assign push_fall  = old_pins.push & ~new_pins.push;
  assign inner_edge = old_pins.a_inner ^ new_pins.a_inner;
  assign outer_edge = old_pins.a_outer ^ new_pins.a_outer;
  assign inner_ccw  = new_pins.a_inner == new_pins.b_inner;
  assign outer_ccw  = new_pins.a_outer == new_pins.b_outer;

  // Turn is judged against the push level after this tick's edge
  always_comb begin
    events        = '0;
    alt_used_next = alt_used;
    if (push_fall) begin
      if (alt_used) begin
        alt_used_next = 1'b0;
      end else begin
        events[EV_PUSH] = 1'b1;
      end
    end
    if (inner_edge) begin
      if (new_pins.push) begin
        events[EV_INNER_CCW_ALT] = inner_ccw;
        events[EV_INNER_CW_ALT]  = ~inner_ccw;
        alt_used_next            = 1'b1;
      end else begin
        events[EV_INNER_CCW] = inner_ccw;
        events[EV_INNER_CW]  = ~inner_ccw;
      end
    end
    if (outer_edge) begin
      events[EV_OUTER_CCW] = outer_ccw;
      events[EV_OUTER_CW]  = ~outer_ccw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alt_used <= 1'b0;
    end else if (en) begin
      alt_used <= alt_used_next;
    end
  end

endmodule
